### hdl/iirc_pkg.sv
// Package for the IIR compensator with output clamp.
// Holds the data widths, register indexes, sequencer states and the MAC control struct.
// No dependencies; every module of the block imports it.
package iirc_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned CNT_W    = $clog2(DATA_W);
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned DEF_TAPS = 3;
  localparam int unsigned MAX_TAPS = 3;

  localparam logic [REG_IDX_W-1:0] REG_OUT_COEF_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_COEF_0  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN       = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT      = 3'd7;

  localparam logic [DATA_W-1:0]  GAIN_RST  = 16'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'h7fff;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_GAIN,
    ST_FIN
  } seq_state_e;

  typedef struct packed {
    logic en;
    logic load;
    logic clr;
  } mac_ctl_t;

endpackage

### hdl/iir_compensator_with_clamp_core.sv
// Top level of the IIR compensator with symmetric output clamp (direct form I).
// Holds the configuration registers, the tap histories and the output register.
// Depends on iirc_pkg, iirc_seq and iirc_mac.
//
// Input samples arrive on the s_axis channel, one signed 16-bit sample per item.
// Each item yields one result item on the m_axis channel carrying the clamped
// output and the unclamped low 16 bits of the sum.
// Coefficients, gain and limit are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while the block is idle, which the
// block itself does not enforce. A write takes effect at the next edge.
// All arithmetic runs on two bit-serial multiply-accumulate units. The
// feedforward and feedback products are formed in parallel, tap by tap, then
// the gain is applied in one more pass. A new item is taken only once the
// result of the previous item has been written to the output register.
// The result sits in an output register; the next item is accepted while it
// waits, and the core only holds when a second result would overwrite it.
// Reset clears the histories, zeroes the coefficients, sets gain to one and
// limit to 32767, and empties the output register.
module iir_compensator_with_clamp_core
  import iirc_pkg::*;
#(
  parameter int unsigned TAPS = DEF_TAPS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [15:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [2*DATA_W-1:0]    m_axis_tdata,   // [15:0] clamped_output, [31:16] raw_output
  input  logic                   cfg_we_i,
  input  logic [REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  logic [DATA_W-1:0]  out_coef_q [TAPS];
  logic [DATA_W-1:0]  in_coef_q  [TAPS];
  logic [DATA_W-1:0]  gain_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [DATA_W-1:0]  in_hist_q  [TAPS];
  logic [DATA_W-1:0]  out_hist_q [TAPS];

  logic [2*DATA_W-1:0] out_data_q, out_data_d;
  logic                out_valid_q, out_valid_d;

  logic              done, gain_sel, out_free, accept;
  logic [TAP_W-1:0]  tap;
  mac_ctl_t          ff_ctl, fb_ctl;
  logic [DATA_W-1:0] ff_sum, fb_sum, fb_a, fb_b;
  logic signed [DATA_W-1:0] raw, lim, clamped;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  iirc_seq #(
    .TAPS(TAPS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .done_o     (done),
    .gain_sel_o (gain_sel),
    .tap_o      (tap),
    .ff_ctl_o   (ff_ctl),
    .fb_ctl_o   (fb_ctl)
  );

  iirc_mac u_mac_ff (
    .clk_i (clk_i),
    .ctl_i (ff_ctl),
    .a_i   (in_coef_q[tap]),
    .b_i   (in_hist_q[tap]),
    .p_o   (ff_sum)
  );

  assign fb_a = gain_sel ? ff_sum : out_coef_q[tap];
  assign fb_b = gain_sel ? gain_q : out_hist_q[tap];

  iirc_mac u_mac_fb (
    .clk_i (clk_i),
    .ctl_i (fb_ctl),
    .a_i   (fb_a),
    .b_i   (fb_b),
    .p_o   (fb_sum)
  );

  always_comb begin
    raw = $signed(fb_sum);
    lim = $signed({1'b0, limit_q});
    priority if (raw >= lim) begin
      clamped = lim;
    end else if (raw <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        out_coef_q[i] <= '0;
        in_coef_q[i]  <= '0;
      end
      gain_q  <= GAIN_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      for (int i = 0; i < TAPS; i++) begin
        if (cfg_idx_i == REG_OUT_COEF_0 + REG_IDX_W'(i)) begin
          out_coef_q[i] <= cfg_data_i;
        end
        if (cfg_idx_i == REG_IN_COEF_0 + REG_IDX_W'(i)) begin
          in_coef_q[i] <= cfg_data_i;
        end
      end
      if (cfg_idx_i == REG_GAIN) begin
        gain_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_LIMIT) begin
        limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        in_hist_q[i]  <= '0;
        out_hist_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        in_hist_q[0] <= s_axis_tdata;
      end
      if (done) begin
        out_hist_q[0] <= clamped;
        out_hist_q[1] <= clamped;
        in_hist_q[1]  <= in_hist_q[0];
        for (int i = 2; i < TAPS; i++) begin
          in_hist_q[i]  <= in_hist_q[i-1];
          out_hist_q[i] <= out_hist_q[i-1];
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (done) begin
      out_valid_d = 1'b1;
      out_data_d  = {raw, clamped};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input accepted again right after an item was taken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a pending result");

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (clamped <= lim) && (clamped >= -lim))
    else $error("clamped output outside the limit");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ff_ctl.en || fb_ctl.en) |-> !s_axis_tready)
    else $error("input ready while the MAC units are running");

endmodule

### hdl/iirc_mac.sv
// Bit-serial multiply-accumulate unit of the IIR compensator, modulo 2^16.
// Takes one multiplier bit per cycle while enabled, least significant bit first.
// Depends on iirc_pkg.
module iirc_mac
  import iirc_pkg::*;
(
  input  logic              clk_i,
  input  mac_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic [DATA_W-1:0] p_o
);

  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] p_q, p_d;
  logic [DATA_W-1:0] a_cur, b_cur, p_base;

  always_comb begin
    a_cur  = ctl_i.load ? a_i : a_q;
    b_cur  = ctl_i.load ? b_i : b_q;
    p_base = ctl_i.clr ? '0 : p_q;
    if (ctl_i.en) begin
      p_d = b_cur[0] ? p_base + a_cur : p_base;
      a_d = a_cur << 1;
      b_d = b_cur >> 1;
    end else begin
      p_d = p_q;
      a_d = a_q;
      b_d = b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### hdl/iirc_seq.sv
// Sequencer of the IIR compensator: steps through the taps and the gain pass bit by bit.
// Drives the two MAC units and the input and output handshakes of the core.
// Depends on iirc_pkg.
module iirc_seq
  import iirc_pkg::*;
#(
  parameter int unsigned TAPS = DEF_TAPS,
  localparam int unsigned TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  output logic             done_o,
  output logic             gain_sel_o,
  output logic [TAP_W-1:0] tap_o,
  output mac_ctl_t         ff_ctl_o,
  output mac_ctl_t         fb_ctl_o
);

  localparam logic [CNT_W-1:0] CntLast = CNT_W'(DATA_W - 1);
  localparam logic [TAP_W-1:0] TapLast = TAP_W'(TAPS - 1);

  seq_state_e state_q, state_d;
  logic [CNT_W-1:0] bcnt_q, bcnt_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bcnt_q  <= '0;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      tap_q   <= tap_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    bcnt_d     = bcnt_q;
    tap_d      = tap_q;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    gain_sel_o = 1'b0;
    ff_ctl_o   = '0;
    fb_ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        bcnt_d     = '0;
        tap_d      = '0;
        if (in_valid_i) begin
          state_d = ST_TAPS;
        end
      end
      ST_TAPS: begin
        ff_ctl_o.en   = 1'b1;
        ff_ctl_o.load = (bcnt_q == '0);
        ff_ctl_o.clr  = (bcnt_q == '0) && (tap_q == '0);
        fb_ctl_o      = ff_ctl_o;
        bcnt_d        = bcnt_q + 1'b1;
        if (bcnt_q == CntLast) begin
          if (tap_q == TapLast) begin
            state_d = ST_GAIN;
          end else begin
            tap_d = tap_q + 1'b1;
          end
        end
      end
      ST_GAIN: begin
        gain_sel_o    = 1'b1;
        fb_ctl_o.en   = 1'b1;
        fb_ctl_o.load = (bcnt_q == '0);
        bcnt_d        = bcnt_q + 1'b1;
        if (bcnt_q == CntLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign tap_o = tap_q;

endmodule

### tb/iir_compensator_with_clamp_core_test.sv
// Self-checking testbench for iir_compensator_with_clamp_core: a directed run at the
// extremes, then randomized phases of coefficient writes and samples, checked against
// an in-bench filter model. Depends on iirc_pkg and the core RTL only.
module iir_compensator_with_clamp_core_test;
  import iirc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 530;
  localparam int unsigned DRAIN_SETTLE = 8;
  localparam int unsigned TAIL_CYCLES  = 16 * (DEF_TAPS + 1) + 20;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PRINT_CAP    = 40;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_WRITE,
    OP_DRAIN
  } plan_kind_e;

  typedef struct packed {
    plan_kind_e             kind;
    logic [REG_IDX_W-1:0]   idx;
    logic [DATA_W-1:0]      data;
  } plan_entry_t;

  typedef struct packed {
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] clamped;
  } filter_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;   // [15:0] sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*DATA_W-1:0]  m_axis_tdata;        // [15:0] clamped_output, [31:16] raw_output
  logic                 cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  plan_entry_t sample_plan[$];
  filter_out_t expected_outputs[$];

  logic [DATA_W-1:0]  out_coef_reg [MAX_TAPS];
  logic [DATA_W-1:0]  in_coef_reg [MAX_TAPS];
  logic [DATA_W-1:0]  gain_reg = GAIN_RST;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RST;
  logic [DATA_W-1:0]  in_hist [MAX_TAPS];
  logic [DATA_W-1:0]  out_hist [MAX_TAPS];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  bit          quiet = 1'b0;

  int unsigned send_gap = 0;
  int unsigned drain_wait = 0;
  int unsigned stall_left = 0;
  logic        nxt_valid;
  logic        nxt_we;
  logic        nxt_ready;
  plan_entry_t entry;
  filter_out_t got;
  filter_out_t want;

  iir_compensator_with_clamp_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      out_coef_reg[i] = '0;
      in_coef_reg[i]  = '0;
      in_hist[i]      = '0;
      out_hist[i]     = '0;
    end
  end

  function automatic void apply_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    if (idx < REG_IN_COEF_0) begin
      out_coef_reg[idx - REG_OUT_COEF_0] = data;
    end else if (idx < REG_GAIN) begin
      in_coef_reg[idx - REG_IN_COEF_0] = data;
    end else if (idx == REG_GAIN) begin
      gain_reg = data;
    end else begin
      limit_reg = data[LIMIT_W-1:0];
    end
  endfunction

  // Direct form I step; every product and sum wraps at 32 bits.
  function automatic filter_out_t filter_step(logic [DATA_W-1:0] sample);
    logic signed [31:0] acc;
    logic signed [31:0] ff;
    logic signed [31:0] g;
    logic signed [DATA_W-1:0] raw;
    logic signed [DATA_W-1:0] lim;
    logic signed [DATA_W-1:0] clamped;
    filter_out_t r;
    acc = '0;
    g = $signed(gain_reg);
    in_hist[0] = sample;
    for (int i = 0; i < DEF_TAPS; i++) begin
      ff  = $signed(in_coef_reg[i]) * $signed(in_hist[i]);
      acc = acc + $signed(out_coef_reg[i]) * $signed(out_hist[i]);
      acc = acc + g * ff;
    end
    raw = acc[DATA_W-1:0];
    lim = $signed({1'b0, limit_reg});
    if (raw >= lim) begin
      clamped = lim;
    end else if (raw <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = raw;
    end
    out_hist[0] = clamped;
    for (int i = DEF_TAPS - 1; i > 0; i--) begin
      in_hist[i]  = in_hist[i-1];
      out_hist[i] = out_hist[i-1];
    end
    r.raw = raw;
    r.clamped = clamped;
    return r;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 150);
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] seen, logic [DATA_W-1:0] ideal);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH result %0d %s: got %h, expected %h", result_count, field, seen, ideal);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 512 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sender: plays back the plan, applying register writes only once drained.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_we_i <= 1'b0;
      send_gap = 0;
      drain_wait = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_we = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outputs.push_back(filter_step(s_axis_tdata));
        nxt_valid = 1'b0;
        send_gap = idle_length();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_plan.size() != 0) begin
          entry = sample_plan[0];
          case (entry.kind)
            OP_SAMPLE: begin
              nxt_valid = 1'b1;
              s_axis_tdata <= entry.data;
              void'(sample_plan.pop_front());
            end
            OP_WRITE: begin
              nxt_we = 1'b1;
              cfg_idx_i <= entry.idx;
              cfg_data_i <= entry.data;
              apply_write(entry.idx, entry.data);
              void'(sample_plan.pop_front());
            end
            default: begin
              if (expected_outputs.size() == 0 && !m_axis_tvalid) begin
                if (drain_wait >= DRAIN_SETTLE) begin
                  drain_wait = 0;
                  void'(sample_plan.pop_front());
                end else begin
                  drain_wait++;
                end
              end else begin
                drain_wait = 0;
              end
            end
          endcase
        end
      end
      s_axis_tvalid <= nxt_valid;
      cfg_we_i <= nxt_we;
    end
  end

  // Receiver: random back-pressure and in-order checking.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected result", got.clamped, '0);
        end else begin
          want = expected_outputs.pop_front();
          if (got.clamped !== want.clamped) begin
            report_mismatch("clamped_output", got.clamped, want.clamped);
          end
          if (got.raw !== want.raw) begin
            report_mismatch("raw_output", got.raw, want.raw);
          end
        end
        result_count++;
      end
      nxt_ready = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = idle_length();
        nxt_ready = (stall_left == 0);
      end
      m_axis_tready <= nxt_ready;
    end
  end

  task automatic plan_sample(logic [DATA_W-1:0] data);
    sample_plan.push_back('{kind: OP_SAMPLE, idx: '0, data: data});
  endtask

  task automatic plan_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    sample_plan.push_back('{kind: OP_WRITE, idx: idx, data: data});
  endtask

  task automatic plan_drain();
    sample_plan.push_back('{kind: OP_DRAIN, idx: '0, data: '0});
  endtask

  function automatic logic [DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h0001;
      4, 5, 6: return DATA_W'($urandom_range(0, 511) - 256);
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3, 4: return DATA_W'($urandom_range(1, 2000));
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int unsigned remaining;
    int unsigned len;

    // Reset defaults: every coefficient is zero, so the output stays zero.
    plan_sample(16'h1234);
    plan_sample(16'h8000);

    // Pass-through, hitting the clamp at both extremes.
    plan_drain();
    plan_write(REG_IN_COEF_0, 16'h0001);
    plan_sample(16'h7fff);
    plan_sample(16'h8000);
    plan_sample(16'hffff);
    plan_sample(16'h0001);
    plan_sample(16'h0000);
    plan_sample(16'h8001);
    plan_sample(16'h5555);
    plan_sample(16'haaaa);

    // A zero limit forces every output to zero.
    plan_drain();
    plan_write(REG_LIMIT, 16'h0000);
    plan_sample(16'h7fff);
    plan_sample(16'h8000);
    plan_sample(16'h0003);

    // Extreme coefficients and gain; the first input tap keeps its coefficient of one.
    plan_drain();
    plan_write(REG_LIMIT, 16'd100);
    plan_write(REG_OUT_COEF_0, 16'h7fff);
    plan_write(REG_IDX_W'(REG_OUT_COEF_0 + 1), 16'h8000);
    plan_write(REG_IDX_W'(REG_OUT_COEF_0 + 2), 16'hffff);
    plan_write(REG_IDX_W'(REG_IN_COEF_0 + 1), 16'h8000);
    plan_write(REG_IDX_W'(REG_IN_COEF_0 + 2), 16'h7fff);
    plan_write(REG_GAIN, 16'h8000);
    plan_sample(16'h7fff);
    plan_sample(16'h8000);
    plan_sample(16'hffff);
    plan_sample(16'h0001);
    plan_sample(16'h1234);
    plan_sample(16'h8000);

    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      plan_drain();
      for (int i = 0; i < MAX_TAPS; i++) begin
        if ($urandom_range(0, 1)) plan_write(REG_IDX_W'(REG_OUT_COEF_0 + i), pick_coef());
        if ($urandom_range(0, 1)) plan_write(REG_IDX_W'(REG_IN_COEF_0 + i), pick_coef());
      end
      if ($urandom_range(0, 1)) plan_write(REG_GAIN, pick_coef());
      if ($urandom_range(0, 1)) plan_write(REG_LIMIT, pick_limit());
      len = $urandom_range(20, 60);
      if (len > remaining) len = remaining;
      repeat (len) plan_sample(pick_sample());
      remaining -= len;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_plan.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
